// File: rtl/lfa_pkg.sv
// Package for the LED strip flow animator: sequencer states, register map,
// reset values, fade and palette constants, and the modulo unit request.
// No dependencies.
package lfa_pkg;

    // Stream payload widths
    localparam int PIX_IDX_W = 7;
    localparam int COLOR_W   = 24;
    localparam int CHAN_W    = 8;

    // Configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CNT_W      = 16;

    // Register indexes (byte address is four times the index)
    localparam logic [2:0] REG_FRAME_INTERVAL = 3'd0;
    localparam logic [2:0] REG_PHASE_PERIOD   = 3'd1;
    localparam logic [2:0] REG_COLOR_A_FIRST  = 3'd2;
    localparam logic [2:0] REG_COLOR_B_FIRST  = 3'd3;
    localparam logic [2:0] REG_COLOR_A_SECOND = 3'd4;
    localparam logic [2:0] REG_COLOR_B_SECOND = 3'd5;
    localparam logic [2:0] REG_COLOR_A_THIRD  = 3'd6;
    localparam logic [2:0] REG_COLOR_B_THIRD  = 3'd7;

    // Register reset values
    localparam logic [CNT_W-1:0]   RST_FRAME_INTERVAL = 16'd50;
    localparam logic [CNT_W-1:0]   RST_PHASE_PERIOD   = 16'd900;
    localparam logic [COLOR_W-1:0] RST_COLOR_A_FIRST  = 24'hFF640A;
    localparam logic [COLOR_W-1:0] RST_COLOR_B_FIRST  = 24'hFF0050;
    localparam logic [COLOR_W-1:0] RST_COLOR_A_SECOND = 24'hC8271E;
    localparam logic [COLOR_W-1:0] RST_COLOR_B_SECOND = 24'h0AFF64;
    localparam logic [COLOR_W-1:0] RST_COLOR_A_THIRD  = 24'h5A2887;
    localparam logic [COLOR_W-1:0] RST_COLOR_B_THIRD  = 24'h1E1EFF;

    // Input command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Frame count residue mod 100 drives latch and fade
    localparam int         LOOP_W       = 7;
    localparam logic [6:0] FIRST_PERIOD = 7'd100;
    localparam logic [6:0] LATCH_PERIOD = 7'd50;
    localparam logic [6:0] FADE_LOOP    = 7'd25;
    localparam logic [6:0] FADE_LOOP_X2 = 7'd50;
    localparam logic [6:0] FADE_LOOP_X3 = 7'd75;
    localparam int         FADE_W       = 5;
    localparam logic [4:0] FADE_DEN     = 5'd24;
    localparam int         PROD_W       = CHAN_W + FADE_W;

    // floor(x/3) = (x * RECIP3) >> RECIP3_SHIFT, exact for x < 2**17
    localparam int          RECIP3_SHIFT = 17;
    localparam logic [15:0] RECIP3       = 16'd43691;

    // Iterative modulo: four bits per cycle over a 16-bit dividend
    localparam int DIV_W       = 16;
    localparam int DIV_BITS    = 4;
    localparam int DIV_STEPS   = DIV_W / DIV_BITS;
    localparam int DIV_STEP_W  = $clog2(DIV_STEPS);

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } mod_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SELECT,
        ST_FADE_MUL,
        ST_FADE_DIV,
        ST_INSERT,
        ST_READ,
        ST_EMIT
    } state_t;

endpackage

// File: rtl/lfa_mod.sv
// Iterative restoring modulo unit: remainder of a 16-bit dividend by a
// 16-bit divisor, four bits per cycle. A zero divisor returns the dividend.
// Depends on lfa_pkg.
module lfa_mod (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lfa_pkg::mod_req_t        req,
    output logic                     done,
    output logic [lfa_pkg::DIV_W-1:0] rem
);
    import lfa_pkg::*;

    logic                  busy_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic                  done_reg;
    logic [DIV_W-1:0]      quo_reg;
    logic [DIV_W-1:0]      div_reg;
    logic [DIV_W:0]        rem_reg;
    logic [DIV_W-1:0]      quo_next;
    logic [DIV_W:0]        rem_next;

    // Shift in four dividend bits, subtract the divisor where it fits
    always_comb
    begin
        logic [DIV_W:0]   r;
        logic [DIV_W-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int j = 0; j < DIV_BITS; j++)
        begin
            r = {r[DIV_W-1:0], q[DIV_W-1]};
            q = {q[DIV_W-2:0], 1'b0};
            if (r >= {1'b0, div_reg})
            begin
                r = r - {1'b0, div_reg};
            end
        end
        rem_next = r;
        quo_next = q;
    end

    // Control: count steps, pulse done after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == DIV_STEP_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then advance the partial remainder
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            div_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg[DIV_W-1:0];

endmodule

// File: rtl/lfa_cell.sv
// One pixel cell of the rotating strip ring: takes its neighbor's pixel
// every cycle, or a new pixel when loaded.
// Depends on lfa_pkg.
module lfa_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [lfa_pkg::COLOR_W-1:0] load_px,
    input  logic [lfa_pkg::COLOR_W-1:0] prev_px,
    output logic [lfa_pkg::COLOR_W-1:0] px
);
    import lfa_pkg::*;

    logic [COLOR_W-1:0] px_reg;
    logic [COLOR_W-1:0] px_next;

    // Select the neighbor or the injected pixel
    assign px_next = load ? load_px : prev_px;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg <= '0;
        end
        else
        begin
            px_reg <= px_next;
        end
    end

    assign px = px_reg;

endmodule

// File: rtl/lfa_chain.sv
// Pixel strip as a ring of cells that rotates by one cell every cycle.
// A tap counter tracks the strip position seen at the last cell.
// Depends on lfa_pkg and lfa_cell.
module lfa_chain #(
    parameter int STRIP_LENGTH = 92
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             inject,
    input  logic [lfa_pkg::COLOR_W-1:0]      inject_px,
    output logic [$clog2(STRIP_LENGTH)-1:0]  tap_idx,
    output logic [lfa_pkg::COLOR_W-1:0]      tap_px
);
    import lfa_pkg::*;

    localparam int TAP_W = $clog2(STRIP_LENGTH);
    localparam logic [TAP_W-1:0] LAST_IDX = TAP_W'(STRIP_LENGTH - 1);

    logic [COLOR_W-1:0] cell_px [STRIP_LENGTH];
    logic [TAP_W-1:0]   tap_reg;
    logic [TAP_W-1:0]   tap_next;

    // Build the ring: cell 0 closes the loop from the last cell
    for (genvar j = 0; j < STRIP_LENGTH; j++)
    begin : g_cell
        if (j == 0)
        begin : g_head
            lfa_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .load    (inject),
                .load_px (inject_px),
                .prev_px (cell_px[STRIP_LENGTH-1]),
                .px      (cell_px[0])
            );
        end
        else
        begin : g_body
            lfa_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .load    (1'b0),
                .load_px (inject_px),
                .prev_px (cell_px[j-1]),
                .px      (cell_px[j])
            );
        end
    end

    // Step the tap position down; an injection renumbers the strip and holds it
    always_comb
    begin
        if (inject)
        begin
            tap_next = tap_reg;
        end
        else if (tap_reg == '0)
        begin
            tap_next = LAST_IDX;
        end
        else
        begin
            tap_next = tap_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= LAST_IDX;
        end
        else
        begin
            tap_reg <= tap_next;
        end
    end

    assign tap_idx = tap_reg;
    assign tap_px  = cell_px[STRIP_LENGTH-1];

endmodule

// File: rtl/led_strip_flow_animator_unit.sv
// Top level of the LED strip flow animator: register file, item sequencer,
// palette and fade datapath, output register.
// Depends on lfa_pkg, lfa_mod, lfa_chain.
//
//  channel   direction  transaction                     payload
//  s_*       in         s_tvalid & s_tready             tdata pixel_index, tuser cmd
//  m_*       out        m_tvalid & m_tready             tdata r,g,b, tuser frame_stepped
//  APB       in         psel & penable & pwrite         8 registers at 4*i
//
// A tick without a frame step goes from idle straight to emit. A frame step runs
// the modulo unit's 4 steps, then select, fade multiply and fade divide, and then
// waits in insert for the ring to bring the last pixel to the tap. A pixel read
// waits in read for the same ring rotation to bring the addressed pixel to the
// tap.
// Reset is asynchronous: registers take their defaults and every cell clears
// at once. A result waits in the output register while m_tready is low; the
// next item is taken meanwhile and its result holds until that one leaves.
module led_strip_flow_animator_unit #(
    parameter int STRIP_LENGTH = 92
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // stream in
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [6:0] pixel_index
    input  logic [0:0]                     s_tuser,  // [0] cmd
    // stream out
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,  // [7:0] red, [15:8] green, [23:16] blue
    output logic [0:0]                     m_tuser,  // [0] frame_stepped
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lfa_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lfa_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lfa_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import lfa_pkg::*;

    localparam int TAP_W = $clog2(STRIP_LENGTH);
    localparam int CMP_W = ((TAP_W > PIX_IDX_W) ? TAP_W : PIX_IDX_W) + 1;
    localparam logic [TAP_W-1:0] LAST_IDX = TAP_W'(STRIP_LENGTH - 1);

    // Configuration registers
    logic [CNT_W-1:0]   frame_interval_reg;
    logic [CNT_W-1:0]   phase_period_reg;
    logic [COLOR_W-1:0] color_a_first_reg;
    logic [COLOR_W-1:0] color_b_first_reg;
    logic [COLOR_W-1:0] color_a_second_reg;
    logic [COLOR_W-1:0] color_b_second_reg;
    logic [COLOR_W-1:0] color_a_third_reg;
    logic [COLOR_W-1:0] color_b_third_reg;
    logic               cfg_write;
    logic [2:0]         cfg_idx;

    // Animation state
    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   prescaler_reg;
    logic [CNT_W-1:0]   frame_count_reg;
    logic [LOOP_W-1:0]  loop_reg;
    logic [COLOR_W-1:0] active_first_reg;
    logic [COLOR_W-1:0] active_second_reg;
    logic [COLOR_W-1:0] flow_color_reg;
    logic [CNT_W-1:0]   third_reg;
    logic [CNT_W-1:0]   two_thirds_reg;
    logic [FADE_W-1:0]  fade_k_reg;
    logic [PROD_W-1:0]  prod_r_reg;
    logic [PROD_W-1:0]  prod_g_reg;
    logic [PROD_W-1:0]  prod_b_reg;
    logic [PIX_IDX_W-1:0] read_idx_reg;
    logic               res_stepped_reg;
    logic [COLOR_W-1:0] res_px_reg;

    // Output register
    logic               m_tvalid_reg;
    logic [23:0]        m_tdata_reg;
    logic               m_tuser_reg;

    // Combinational helpers
    logic               in_accept;
    logic [CNT_W-1:0]   prescaler_inc;
    logic               step_hit;
    logic               idx_in_range;
    logic [LOOP_W-1:0]  loop_inc;
    logic [32:0]        third_prod;
    logic [32:0]        two_thirds_prod;
    logic [COLOR_W-1:0] pair_first;
    logic [COLOR_W-1:0] pair_second;
    logic [FADE_W-1:0]  fade_k_next;
    logic [FADE_W-1:0]  fade_weight;
    logic [25:0]        quot_r;
    logic [25:0]        quot_g;
    logic [25:0]        quot_b;
    logic               tap_match;
    logic               out_load;
    logic               inject;
    mod_req_t           mod_req;
    logic               mod_done;
    logic [DIV_W-1:0]   mod_rem;
    logic [TAP_W-1:0]   tap_idx;
    logic [COLOR_W-1:0] tap_px;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_idx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_interval_reg <= RST_FRAME_INTERVAL;
            phase_period_reg   <= RST_PHASE_PERIOD;
            color_a_first_reg  <= RST_COLOR_A_FIRST;
            color_b_first_reg  <= RST_COLOR_B_FIRST;
            color_a_second_reg <= RST_COLOR_A_SECOND;
            color_b_second_reg <= RST_COLOR_B_SECOND;
            color_a_third_reg  <= RST_COLOR_A_THIRD;
            color_b_third_reg  <= RST_COLOR_B_THIRD;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_FRAME_INTERVAL: frame_interval_reg <= pwdata[CNT_W-1:0];
                REG_PHASE_PERIOD:   phase_period_reg   <= pwdata[CNT_W-1:0];
                REG_COLOR_A_FIRST:  color_a_first_reg  <= pwdata[COLOR_W-1:0];
                REG_COLOR_B_FIRST:  color_b_first_reg  <= pwdata[COLOR_W-1:0];
                REG_COLOR_A_SECOND: color_a_second_reg <= pwdata[COLOR_W-1:0];
                REG_COLOR_B_SECOND: color_b_second_reg <= pwdata[COLOR_W-1:0];
                REG_COLOR_A_THIRD:  color_a_third_reg  <= pwdata[COLOR_W-1:0];
                REG_COLOR_B_THIRD:  color_b_third_reg  <= pwdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (cfg_idx)
            REG_FRAME_INTERVAL: prdata = CFG_DATA_W'(frame_interval_reg);
            REG_PHASE_PERIOD:   prdata = CFG_DATA_W'(phase_period_reg);
            REG_COLOR_A_FIRST:  prdata = CFG_DATA_W'(color_a_first_reg);
            REG_COLOR_B_FIRST:  prdata = CFG_DATA_W'(color_b_first_reg);
            REG_COLOR_A_SECOND: prdata = CFG_DATA_W'(color_a_second_reg);
            REG_COLOR_B_SECOND: prdata = CFG_DATA_W'(color_b_second_reg);
            REG_COLOR_A_THIRD:  prdata = CFG_DATA_W'(color_a_third_reg);
            REG_COLOR_B_THIRD:  prdata = CFG_DATA_W'(color_b_third_reg);
            default:            prdata = '0;
        endcase
    end

    // Phase thresholds floor(t/3) and floor(2t/3), refreshed every cycle
    assign third_prod      = 33'(phase_period_reg) * 33'(RECIP3);
    assign two_thirds_prod = 33'({phase_period_reg, 1'b0}) * 33'(RECIP3);

    always_ff @(posedge clk)
    begin
        third_reg      <= third_prod[RECIP3_SHIFT +: CNT_W];
        two_thirds_reg <= two_thirds_prod[RECIP3_SHIFT +: CNT_W];
    end

    // ------------------------------------------------------------------
    // Item decode
    // ------------------------------------------------------------------
    assign in_accept     = s_tvalid & s_tready;
    assign prescaler_inc = prescaler_reg + 1'b1;
    assign step_hit      = (prescaler_inc >= frame_interval_reg);
    assign idx_in_range  = (CMP_W'(s_tdata[PIX_IDX_W-1:0]) < CMP_W'(STRIP_LENGTH));
    assign loop_inc      = (frame_count_reg == {CNT_W{1'b1}}) ? '0 :
                           (loop_reg == FIRST_PERIOD - 1'b1) ? '0 : loop_reg + 1'b1;
    assign tap_match     = (CMP_W'(tap_idx) == CMP_W'(read_idx_reg));

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser[0] == CMD_TICK)
                    begin
                        state_next = step_hit ? ST_DIVIDE : ST_EMIT;
                    end
                    else
                    begin
                        state_next = idx_in_range ? ST_READ : ST_EMIT;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (mod_done)
                begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:   state_next = ST_FADE_MUL;
            ST_FADE_MUL: state_next = ST_FADE_DIV;
            ST_FADE_DIV: state_next = ST_INSERT;
            ST_INSERT:
            begin
                if (tap_idx == LAST_IDX)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_READ:
            begin
                if (tap_match)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready         = 1'b0;
        mod_req.start    = 1'b0;
        mod_req.dividend = prescaler_inc;
        mod_req.divisor  = phase_period_reg;
        inject           = 1'b0;
        out_load         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready      = 1'b1;
                mod_req.start = s_tvalid & (s_tuser[0] == CMD_TICK) & step_hit;
            end
            ST_INSERT: inject   = (tap_idx == LAST_IDX);
            ST_EMIT:   out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
        // the modulo works on the incremented frame count
        mod_req.dividend = frame_count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Palette choice and fade
    // ------------------------------------------------------------------
    always_comb
    begin
        if (mod_rem < third_reg)
        begin
            pair_first  = color_a_first_reg;
            pair_second = color_b_first_reg;
        end
        else if (mod_rem < two_thirds_reg)
        begin
            pair_first  = color_a_second_reg;
            pair_second = color_b_second_reg;
        end
        else
        begin
            pair_first  = color_a_third_reg;
            pair_second = color_b_third_reg;
        end
    end

    // k = count mod 25, taken from the count mod 100
    always_comb
    begin
        if (loop_reg >= FADE_LOOP_X3)
        begin
            fade_k_next = FADE_W'(loop_reg - FADE_LOOP_X3);
        end
        else if (loop_reg >= FADE_LOOP_X2)
        begin
            fade_k_next = FADE_W'(loop_reg - FADE_LOOP_X2);
        end
        else if (loop_reg >= FADE_LOOP)
        begin
            fade_k_next = FADE_W'(loop_reg - FADE_LOOP);
        end
        else
        begin
            fade_k_next = FADE_W'(loop_reg);
        end
    end

    assign fade_weight = FADE_DEN - fade_k_reg;

    // floor(p/24) as floor(floor(p/8)/3)
    assign quot_r = 26'(prod_r_reg[PROD_W-1:3]) * 26'(RECIP3);
    assign quot_g = 26'(prod_g_reg[PROD_W-1:3]) * 26'(RECIP3);
    assign quot_b = 26'(prod_b_reg[PROD_W-1:3]) * 26'(RECIP3);

    // ------------------------------------------------------------------
    // Animation state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescaler_reg     <= '0;
            frame_count_reg   <= '0;
            loop_reg          <= '0;
            active_first_reg  <= '0;
            active_second_reg <= '0;
            flow_color_reg    <= '0;
        end
        else
        begin
            // advance the prescaler, step the frame count on a hit
            if (in_accept && (s_tuser[0] == CMD_TICK))
            begin
                if (step_hit)
                begin
                    prescaler_reg   <= '0;
                    frame_count_reg <= frame_count_reg + 1'b1;
                    loop_reg        <= loop_inc;
                end
                else
                begin
                    prescaler_reg <= prescaler_inc;
                end
            end
            // latch the palette pair and, every 50 counts, the flow color
            if (state_reg == ST_SELECT)
            begin
                active_first_reg  <= pair_first;
                active_second_reg <= pair_second;
                if (loop_reg == '0)
                begin
                    flow_color_reg <= pair_first;
                end
                else if (loop_reg == LATCH_PERIOD)
                begin
                    flow_color_reg <= pair_second;
                end
            end
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            read_idx_reg    <= s_tdata[PIX_IDX_W-1:0];
            res_stepped_reg <= 1'b0;
            res_px_reg      <= '0;
        end
        if (state_reg == ST_SELECT)
        begin
            fade_k_reg <= fade_k_next;
        end
        if (state_reg == ST_FADE_MUL)
        begin
            prod_r_reg <= PROD_W'(flow_color_reg[23:16]) * PROD_W'(fade_weight);
            prod_g_reg <= PROD_W'(flow_color_reg[15:8]) * PROD_W'(fade_weight);
            prod_b_reg <= PROD_W'(flow_color_reg[7:0]) * PROD_W'(fade_weight);
        end
        if (state_reg == ST_FADE_DIV)
        begin
            res_stepped_reg <= 1'b1;
            res_px_reg      <= {quot_r[RECIP3_SHIFT +: CHAN_W],
                                quot_g[RECIP3_SHIFT +: CHAN_W],
                                quot_b[RECIP3_SHIFT +: CHAN_W]};
        end
        if ((state_reg == ST_READ) && tap_match)
        begin
            res_px_reg <= tap_px;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {res_px_reg[7:0], res_px_reg[15:8], res_px_reg[23:16]};
            m_tuser_reg <= res_stepped_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // ------------------------------------------------------------------
    // Submodules
    // ------------------------------------------------------------------
    lfa_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    lfa_chain #(
        .STRIP_LENGTH (STRIP_LENGTH)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .inject    (inject),
        .inject_px (res_px_reg),
        .tap_idx   (tap_idx),
        .tap_px    (tap_px)
    );

endmodule
